FILE: rtl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg: shared types and constants of the bounded list unit
// Word layouts, the cell command set and the controller states.
// ----------------------------------------------------------------------------
package bli_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W       = 8;
  localparam int VAL_W       = 32;

  // operation codes carried in the func field
  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FUNC_APPEND     = 2'd1;
  localparam logic [1:0] FUNC_DELETE     = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    last_of_run;
    logic                    list_empty;
    logic                    insert_dropped;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_APPEND,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] head;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/bli_cell.sv
// ----------------------------------------------------------------------------
// bli_cell: one storage cell of the list chain
// Holds one entry and trades it with its neighbors under a shared command.
// ----------------------------------------------------------------------------
module bli_cell
  import bli_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] right,
  output logic [VAL_W-1:0] value
);

  logic at_tail;
  logic at_end;
  logic from_pos;

  assign at_tail  = (CNT_W'(idx) == ctrl.count);
  assign at_end   = (CNT_W'(idx) == (ctrl.count - CNT_W'(1)));
  assign from_pos = (POS_W'(idx) >= ctrl.position);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_HOLD:   value <= value;
      CELL_PUSH:   value <= left;
      CELL_APPEND: if (at_tail) value <= ctrl.value;
      CELL_DELETE: if (from_pos) value <= right;
      CELL_ROTATE: value <= at_end ? ctrl.head : right;
      default:     value <= value;
    endcase
  end

endmodule

FILE: rtl/bounded_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_unit: ordered list of signed words
// Front insert, back append and indexed delete over a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation word:
//   func 0 pushes item_value at the front, func 1 appends it at the back,
//   func 2 deletes the entry at position (ignored at or past the count),
//   func 3 changes nothing.
//   rsp channel (rsp_valid / rsp_stall / rsp) then carries the whole list,
//   front to back, one word per entry, last_of_run on the final word.
//   An empty list yields one word with list_empty set.
//   insert_dropped marks every word of a run whose insert hit a full list.
// Timing:
//   The operation is applied to the cells in the accept cycle. Emission
//   rotates the chain one cell per cycle while the output register is free to load; the next
//   word is accepted once the last result has entered the output register.
//   The cell chain length (MAX_ENTRIES) bounds a run at MAX_ENTRIES words.
// Reset (rst, synchronous) empties the list and holds req_stall high;
// cell contents are not cleared.
// A stalled rsp holds its word; the chain simply waits.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_unit
  import bli_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] emit_idx;
  logic             dropped;
  logic             accept;
  logic             full;
  logic             is_insert;
  logic             del_hit;
  logic             load;
  logic             empty;
  logic             last;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] cell_val [MAX_ENTRIES];

  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign is_insert = (req.func == FUNC_PUSH_FRONT) || (req.func == FUNC_APPEND);
  assign del_hit   = (req.func == FUNC_DELETE) && (req.position < POS_W'(count));

  // output register can take a word this cycle
  assign load  = (state == ST_EMIT) && (!rsp_valid || !rsp_stall);
  assign empty = (count == '0);
  assign last  = empty || (emit_idx == (count - CNT_W'(1)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_EMIT;
      ST_EMIT: if (load && last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // controller outputs: stall and cell command
  always_comb begin
    req_stall     = 1'b1;
    ctrl.op       = CELL_HOLD;
    ctrl.position = req.position;
    ctrl.count    = count;
    ctrl.value    = req.item_value;
    ctrl.head     = cell_val[0];
    case (state)
      ST_IDLE: begin
        req_stall = rst;
        if (req_valid && !rst) begin
          if (is_insert && !full) begin
            ctrl.op = (req.func == FUNC_PUSH_FRONT) ? CELL_PUSH : CELL_APPEND;
          end else if (del_hit) begin
            ctrl.op = CELL_DELETE;
          end
        end
      end
      ST_EMIT: if (load && !empty) ctrl.op = CELL_ROTATE;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      if (is_insert && !full) count_next = count + CNT_W'(1);
      else if (del_hit)       count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      emit_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) emit_idx <= '0;
      else if (load) emit_idx <= emit_idx + CNT_W'(1);
      if (load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) dropped <= is_insert && full;
    if (load) begin
      rsp.entry_value    <= empty ? '0 : cell_val[0];
      rsp.last_of_run    <= last;
      rsp.list_empty     <= empty;
      rsp.insert_dropped <= dropped;
    end
  end

  // the cell chain: cell 0 is the front of the list
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = ctrl.value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    bli_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctrl  (ctrl),
      .left  (left_val),
      .right (right_val),
      .value (cell_val[i])
    );
  end

endmodule

FILE: rtl/bli_checker.sv
// ----------------------------------------------------------------------------
// bli_checker: port-level checks of the bounded list unit
// Watches both channels and flags words that break the run rules.
// ----------------------------------------------------------------------------
module bli_checker
  import bli_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // stalled result word stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("rsp_valid dropped while stalled");

  // a run is in progress right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken again before its run ended");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.list_empty |-> rsp.last_of_run)
    else $error("empty word not marked last");

  // an empty list cannot have refused an insert
  a_empty_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.list_empty |-> !rsp.insert_dropped)
    else $error("empty list reported a dropped insert");

endmodule

bind bounded_list_insert_delete_unit bli_checker u_bli_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: tb/bli_run_checker.sv
// ----------------------------------------------------------------------------
// bli_run_checker: list predictor and word checker
// Watches the req and rsp channels of the bounded list unit, keeps its own
// copy of the list, queues the words each accepted operation should emit
// and compares every accepted rsp word with the oldest queued one.
// ----------------------------------------------------------------------------
module bli_run_checker
  import bli_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  logic signed [VAL_W-1:0] cells [MAX_ENTRIES];
  logic [CNT_W-1:0]        count;
  rsp_t                    expected_words [$];
  int                      mismatches;
  rsp_t                    want;

  // apply one operation to the local list, then queue the full run
  task automatic apply_and_list(input req_t w);
    int   i;
    logic dropped;
    rsp_t word;
    dropped = 1'b0;
    case (w.func)
      FUNC_PUSH_FRONT, FUNC_APPEND: begin
        if (count >= MAX_ENTRIES) begin
          dropped = 1'b1;
        end else if (w.func == FUNC_PUSH_FRONT) begin
          for (i = int'(count); i > 0; i--) cells[i] = cells[i-1];
          cells[0] = w.item_value;
          count = count + CNT_W'(1);
        end else begin
          cells[count[IDX_W-1:0]] = w.item_value;
          count = count + CNT_W'(1);
        end
      end
      FUNC_DELETE: begin
        if (w.position < count) begin
          for (i = int'(w.position); i + 1 < int'(count); i++) cells[i] = cells[i+1];
          count = count - CNT_W'(1);
        end
      end
      default: ;  // unused selector: list untouched
    endcase
    if (count == 0) begin
      word.entry_value    = '0;
      word.last_of_run    = 1'b1;
      word.list_empty     = 1'b1;
      word.insert_dropped = dropped;
      expected_words.push_back(word);
    end else begin
      for (i = 0; i < int'(count); i++) begin
        word.entry_value    = cells[i];
        word.last_of_run    = (i + 1 == int'(count));
        word.list_empty     = 1'b0;
        word.insert_dropped = dropped;
        expected_words.push_back(word);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count      = '0;
      mismatches = 0;
      expected_words.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      // rsp first: a run queued this edge always sits behind older ones
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected word %h", rsp);
        end else begin
          want = expected_words.pop_front();
          if (rsp.last_of_run !== want.last_of_run ||
              rsp.list_empty !== want.list_empty ||
              rsp.insert_dropped !== want.insert_dropped ||
              (!want.list_empty && rsp.entry_value !== want.entry_value)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch exp val=%0d last=%b empty=%b drop=%b",
                       want.entry_value, want.last_of_run, want.list_empty,
                       want.insert_dropped);
              $display("checker:          got val=%0d last=%b empty=%b drop=%b",
                       rsp.entry_value, rsp.last_of_run, rsp.list_empty,
                       rsp.insert_dropped);
            end
          end
        end
      end
      if (req_valid && !req_stall) apply_and_list(req);
      errors  <= mismatches;
      pending <= expected_words.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: bench for the bounded list unit
// Drives directed and random list operations with random req gaps and rsp
// stalls; the checker instance predicts and compares each word.
// ----------------------------------------------------------------------------
module tb_top;
  import bli_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles with no accepted word
  localparam int TAIL_WAIT  = 40;    // settle time after the last word
  localparam logic [1:0] FUNC_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   rsp_hold = 0;
  bit   quiet = 1'b0;   // no gaps and no stalls while set
  int   sent = 0;

  // 12-unit clock period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bounded_list_insert_delete_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bli_run_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver: after each accepted word, stall for a freshly drawn count.
  always @(posedge clk) begin
    if (rst) begin
      rsp_hold  <= 0;
      rsp_stall <= 1'b0;
    end else if (rsp_valid && !rsp_stall) begin
      int n;
      n = quiet ? 0 : $urandom_range(0, 13);
      rsp_hold  <= n;
      rsp_stall <= (n != 0);
    end else if (rsp_hold != 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_stall <= (rsp_hold > 1);
    end
  end

  // Watchdog: any accepted word on either side resets the idle count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic req_t op_word(logic [1:0] f, logic [31:0] v, logic [7:0] p);
    req_t w;
    w.func       = f;
    w.item_value = v;
    w.position   = p;
    return w;
  endfunction

  // Present one word after a random gap and hold it until accepted.
  // With a zero gap valid stays high straight into the next word.
  task automatic send_word(input req_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  // Hold the request side until every queued word has come out.
  task automatic drain_runs();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] draw_position();
    // mostly near the live range so deletes actually hit entries
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 33));
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 mixes
  function automatic logic [1:0] draw_func(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return (r < 45) ? FUNC_PUSH_FRONT : (r < 85) ? FUNC_APPEND :
                      (r < 97) ? FUNC_DELETE : FUNC_NOP;
      1:       return (r < 10) ? FUNC_PUSH_FRONT : (r < 20) ? FUNC_APPEND :
                      (r < 95) ? FUNC_DELETE : FUNC_NOP;
      default: return (r < 30) ? FUNC_PUSH_FRONT : (r < 60) ? FUNC_APPEND :
                      (r < 95) ? FUNC_DELETE : FUNC_NOP;
    endcase
  endfunction

  initial begin
    int mode;
    int len;
    int blk;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty list, extremes, edges of delete ---
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));        // delete on empty
    send_word(op_word(FUNC_DELETE, $urandom, 8'hFF));
    send_word(op_word(FUNC_NOP, $urandom, 8'($urandom)));   // unused selector
    send_word(op_word(FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 8'hFF));
    send_word(op_word(FUNC_APPEND, 32'h8000_0000, 8'h00));
    send_word(op_word(FUNC_PUSH_FRONT, 32'h0000_0000, 8'hAA));
    send_word(op_word(FUNC_APPEND, 32'hFFFF_FFFF, 8'h55));
    send_word(op_word(FUNC_NOP, $urandom, 8'd0));
    send_word(op_word(FUNC_DELETE, $urandom, 8'hFF));        // far past count
    send_word(op_word(FUNC_DELETE, $urandom, 8'd4));         // exactly count
    send_word(op_word(FUNC_DELETE, $urandom, 8'd1));         // middle
    send_word(op_word(FUNC_DELETE, $urandom, 8'd2));         // tail
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));         // head
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));         // back to empty
    send_word(op_word(FUNC_APPEND, 32'h5555_5555, 8'h0F));
    send_word(op_word(FUNC_PUSH_FRONT, 32'hAAAA_AAAA, 8'hF0));
    send_word(op_word(FUNC_DELETE, $urandom, 8'd5));
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));

    // --- fill past full: drops, then edge deletes on a full list ---
    repeat (38)
      send_word(op_word($urandom_range(0, 1) ? FUNC_APPEND : FUNC_PUSH_FRONT,
                        draw_value(), draw_position()));
    send_word(op_word(FUNC_DELETE, $urandom, 8'(MAX_ENTRIES - 1)));
    send_word(op_word(FUNC_DELETE, $urandom, 8'd0));
    send_word(op_word(FUNC_APPEND, draw_value(), 8'($urandom)));
    send_word(op_word(FUNC_PUSH_FRONT, draw_value(), 8'($urandom)));
    send_word(op_word(FUNC_APPEND, draw_value(), 8'($urandom))); // dropped again

    drain_runs();

    // --- random blocks with shifting bias and occasional quiet stretches ---
    blk = 0;
    while (sent < 165) begin
      mode  = $urandom_range(0, 2);
      len   = $urandom_range(10, 25);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (len)
        send_word(op_word(draw_func(mode), draw_value(), draw_position()));
      blk++;
      if (blk % 4 == 0) drain_runs();
    end
    quiet = 1'b0;

    // wait out every queued run, then let the pipe settle
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_WAIT) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bli_pkg.sv
rtl/bli_cell.sv
rtl/bounded_list_insert_delete_unit.sv
rtl/bli_checker.sv
tb/bli_run_checker.sv
tb/tb_top.sv
